// ----- rtl/iee_pkg.sv -----
`timescale 1ns / 1ps
// iee_pkg: shared types and constants of the image effect engine.
// Used by iee_back and image_effect_engine; depends on nothing.
package iee_pkg;

  // default parameter values
  localparam int FRAME_SIZE_DEF = 256;
  localparam int MAX_RADIUS_DEF = 30;
  localparam int CMD_FIFO_DEPTH = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_EFFECT_MODE = 2'd0;
  localparam logic [1:0] CFG_BLUR_RADIUS = 2'd1;
  localparam logic [1:0] CFG_VIG_STRENGTH = 2'd2;
  localparam logic [1:0] CFG_VIG_RADIUS = 2'd3;

  // effect codes; anything else passes the pixel through
  localparam logic [2:0] MODE_BLUR = 3'd1;
  localparam logic [2:0] MODE_VIGNETTE = 3'd2;
  localparam logic [2:0] MODE_GRAY = 3'd3;
  localparam logic [2:0] MODE_INVERT = 3'd4;

  // register reset values
  localparam logic [2:0] RST_EFFECT_MODE = 3'd0;
  localparam logic [4:0] RST_BLUR_RADIUS = 5'd8;
  localparam logic [10:0] RST_VIG_STRENGTH = 11'd128;
  localparam logic [15:0] RST_VIG_RADIUS = 16'd1536;

  // grayscale weights, Q16
  localparam logic [15:0] GRAY_WR = 16'd19595;
  localparam logic [15:0] GRAY_WG = 16'd38470;
  localparam logic [15:0] GRAY_WB = 16'd7471;

  typedef struct packed {
    logic [2:0]  effect_mode;
    logic [4:0]  blur_radius;
    logic [10:0] vignette_strength;
    logic [15:0] vignette_radius;
  } cfg_t;

endpackage

// ----- rtl/iee_cmd_fifo.sv -----
`timescale 1ns / 1ps
// iee_cmd_fifo: short command queue between the front and the back end.
// Depends on nothing; width and depth come from parameters.
module iee_cmd_fifo #(
  parameter int W = 49,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  buf_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = buf_r[rp_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) buf_r[wp_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

// ----- rtl/iee_div.sv -----
`timescale 1ns / 1ps
// iee_div: iterative restoring unsigned divider, one quotient bit a cycle.
// Shared by the blur average and the vignette falloff; no dependencies.
module iee_div #(
  parameter int NW = 24,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int IW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [IW-1:0] it_r;
  logic          busy_r, done_r;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_r[DW-1:0], q_r[NW-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});
  assign done   = done_r;
  assign quo    = q_r;

  // datapath: dividend shifts out, quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        it_r <= it_r + 1'b1;
        if (it_r == IW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/iee_back.sv -----
`timescale 1ns / 1ps
// iee_back: back end of the effect engine: frame memory, effect sequencer,
// output register. Depends on iee_pkg and iee_div.
module iee_back
  import iee_pkg::*;
#(
  parameter int FRAME_SIZE = FRAME_SIZE_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          cmd_valid,
  input  logic                          cmd_read,
  input  logic [$clog2(FRAME_SIZE)-1:0] cmd_x,
  input  logic [$clog2(FRAME_SIZE)-1:0] cmd_y,
  input  logic [31:0]                   cmd_pixel,
  output logic                          cmd_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [7:0]                    out_alpha
);
  localparam int CW     = $clog2(FRAME_SIZE);
  localparam int AW     = $clog2(FRAME_SIZE * FRAME_SIZE);
  localparam int RBW    = $clog2(MAX_RADIUS + 1);
  localparam int XW     = ((CW > RBW) ? CW : RBW) + 2;
  localparam int WIN    = 2 * MAX_RADIUS + 1;
  localparam int CNTW   = $clog2(WIN * WIN + 1);
  localparam int SUMW   = $clog2(255 * WIN * WIN + 1);
  localparam int SQW    = $clog2(2 * FRAME_SIZE * FRAME_SIZE * 64 + 1);
  localparam int RTW    = (SQW + 1) / 2;
  localparam int VW2    = 2 * RTW;
  localparam int RIW    = $clog2(RTW + 1);
  localparam int VNW    = RTW + 5;
  localparam int FW     = $clog2(FRAME_SIZE + 1);
  localparam int NW     = (SUMW > VNW) ? SUMW : VNW;
  localparam int DW     = (CNTW > FW) ? CNTW : FW;
  localparam int CMPW   = ((RTW > 16) ? RTW : 16) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RADDR, S_PIX, S_BL_RUN, S_BL_FLUSH, S_BL_DIV, S_BL_WAIT,
    S_VG_SQ1, S_VG_SQ2, S_VG_SQRT, S_VG_DIV, S_VG_WAIT, S_VG_FAC, S_VG_APPLY
  } state_t;

  state_t state_r;

  logic [31:0]      mem [FRAME_SIZE * FRAME_SIZE];
  logic [31:0]      rdata_r;
  logic             pend_r;
  logic [AW-1:0]    raddr;
  logic             mem_re;

  logic [CW-1:0]    x_r, y_r;
  logic [31:0]      pix_r;
  logic [RBW-1:0]   r_r;
  logic signed [RBW:0] kx_r, ky_r;
  logic [CNTW-1:0]  cnt_r;
  logic [SUMW-1:0]  sum_r [3];
  logic [1:0]       ch_r;
  logic [7:0]       res_r [3];

  logic [VW2-1:0]   sq_r;
  logic [RTW+2:0]   rem_r;
  logic [RTW-1:0]   root_r;
  logic [RIW-1:0]   it_r;
  logic [8:0]       fall_r;
  logic [8:0]       factor_r;

  logic             out_valid_r;
  logic [7:0]       out_red_r, out_green_r, out_blue_r, out_alpha_r;

  logic             div_start, div_done;
  logic [NW-1:0]    div_num, div_quo;
  logic [DW-1:0]    div_den;

  // blur radius after range limiting
  logic [6:0]       rsel;
  always_comb begin
    rsel = {2'b00, cfg.blur_radius};
    if (rsel == 7'd0) rsel = 7'd1;
    if (rsel > 7'(MAX_RADIUS)) rsel = 7'(MAX_RADIUS);
  end

  logic [RBW:0]     twor1;
  assign twor1 = {rsel[RBW-1:0], 1'b1};

  // window position, edge clamped
  logic signed [XW-1:0] sxs, sys;
  logic [CW-1:0]        sx, sy;
  logic signed [RBW:0]  rs;
  logic                 win_last_x, win_last;
  assign rs  = $signed({1'b0, r_r});
  assign sxs = $signed(XW'({1'b0, x_r})) + XW'(kx_r);
  assign sys = $signed(XW'({1'b0, y_r})) + XW'(ky_r);
  always_comb begin
    if (sxs < 0) sx = '0;
    else if (sxs > $signed(XW'(FRAME_SIZE - 1))) sx = CW'(FRAME_SIZE - 1);
    else sx = sxs[CW-1:0];
    if (sys < 0) sy = '0;
    else if (sys > $signed(XW'(FRAME_SIZE - 1))) sy = CW'(FRAME_SIZE - 1);
    else sy = sys[CW-1:0];
  end
  assign win_last_x = (kx_r == rs);
  assign win_last   = win_last_x && (ky_r == rs);

  // memory address select
  always_comb begin
    if (state_r == S_BL_RUN)
      raddr = AW'(AW'(sy) * AW'(FRAME_SIZE)) + AW'(sx);
    else
      raddr = AW'(AW'(y_r) * AW'(FRAME_SIZE)) + AW'(x_r);
  end
  assign mem_re = (state_r == S_BL_RUN) || (state_r == S_RADDR);

  // command intake: writes need no output slot
  logic [AW-1:0] waddr;
  assign waddr   = AW'(AW'(cmd_y) * AW'(FRAME_SIZE)) + AW'(cmd_x);
  assign cmd_pop = (state_r == S_IDLE) && cmd_valid && (!cmd_read || !out_valid_r);

  // frame memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd_pop && !cmd_read) mem[waddr] <= cmd_pixel;
    if (mem_re) rdata_r <= mem[raddr];
  end

  // grayscale, taken straight from the pixel read
  logic [24:0] gsum;
  assign gsum = 25'(GRAY_WR * rdata_r[7:0]) + 25'(GRAY_WG * rdata_r[15:8])
              + 25'(GRAY_WB * rdata_r[23:16]);

  // vignette distance terms
  logic signed [CW+2:0] hx, hy;
  logic [CW+1:0]        ax, ay;
  assign hx = $signed({2'b00, x_r, 1'b0}) - $signed((CW+3)'(FRAME_SIZE));
  assign hy = $signed({2'b00, y_r, 1'b0}) - $signed((CW+3)'(FRAME_SIZE));
  assign ax = hx[CW+2] ? (CW+2)'(0) - hx[CW+1:0] : hx[CW+1:0];
  assign ay = hy[CW+2] ? (CW+2)'(0) - hy[CW+1:0] : hy[CW+1:0];

  // square root step
  logic [RTW+2:0] rem_sh, trial;
  logic           sq_ge;
  assign rem_sh = {rem_r[RTW:0], sq_r[VW2-1 -: 2]};
  assign trial  = (RTW+3)'({root_r, 2'b01});
  assign sq_ge  = (rem_sh >= trial);

  logic vg_hit;
  logic [RTW-1:0] vg_diff;
  assign vg_hit  = (CMPW'(root_r) > CMPW'(cfg.vignette_radius));
  assign vg_diff = RTW'(CMPW'(root_r) - CMPW'(cfg.vignette_radius));

  // divider operands
  assign div_start = (state_r == S_BL_DIV) || ((state_r == S_VG_DIV) && vg_hit);
  always_comb begin
    if (state_r == S_BL_DIV) begin
      div_num = NW'(sum_r[ch_r]);
      div_den = DW'(cnt_r);
    end else begin
      div_num = NW'({vg_diff, 5'b00000});
      div_den = DW'(FRAME_SIZE);
    end
  end

  iee_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // vignette factor and scaled channels
  logic [19:0] dark_full;
  logic [11:0] dark;
  logic [16:0] vr, vg, vb;
  assign dark_full = fall_r * cfg.vignette_strength;
  assign dark      = 12'(dark_full >> 8);
  assign vr        = pix_r[7:0] * factor_r;
  assign vg        = pix_r[15:8] * factor_r;
  assign vb        = pix_r[23:16] * factor_r;

  // blur accumulation, one window pixel a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= (state_r == S_BL_RUN);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && out_valid_r) out_valid_r <= 1'b0;
      if (pend_r) begin
        sum_r[0] <= sum_r[0] + SUMW'(rdata_r[7:0]);
        sum_r[1] <= sum_r[1] + SUMW'(rdata_r[15:8]);
        sum_r[2] <= sum_r[2] + SUMW'(rdata_r[23:16]);
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_pop && cmd_read) begin
            x_r     <= cmd_x;
            y_r     <= cmd_y;
            state_r <= S_RADDR;
          end
        end
        S_RADDR: state_r <= S_PIX;
        S_PIX: begin
          pix_r <= rdata_r;
          priority case (cfg.effect_mode)
            MODE_BLUR: begin
              r_r      <= rsel[RBW-1:0];
              kx_r     <= -$signed({1'b0, rsel[RBW-1:0]});
              ky_r     <= -$signed({1'b0, rsel[RBW-1:0]});
              cnt_r    <= CNTW'(twor1 * twor1);
              sum_r[0] <= '0;
              sum_r[1] <= '0;
              sum_r[2] <= '0;
              ch_r     <= 2'd0;
              state_r  <= S_BL_RUN;
            end
            MODE_VIGNETTE: state_r <= S_VG_SQ1;
            MODE_GRAY: begin
              out_red_r   <= gsum[23:16];
              out_green_r <= gsum[23:16];
              out_blue_r  <= gsum[23:16];
              out_alpha_r <= rdata_r[31:24];
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
            MODE_INVERT: begin
              out_red_r   <= ~rdata_r[7:0];
              out_green_r <= ~rdata_r[15:8];
              out_blue_r  <= ~rdata_r[23:16];
              out_alpha_r <= rdata_r[31:24];
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
            default: begin
              out_red_r   <= rdata_r[7:0];
              out_green_r <= rdata_r[15:8];
              out_blue_r  <= rdata_r[23:16];
              out_alpha_r <= rdata_r[31:24];
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          endcase
        end
        S_BL_RUN: begin
          if (win_last) begin
            state_r <= S_BL_FLUSH;
          end else if (win_last_x) begin
            kx_r <= -rs;
            ky_r <= ky_r + 1'b1;
          end else begin
            kx_r <= kx_r + 1'b1;
          end
        end
        S_BL_FLUSH: state_r <= S_BL_DIV;
        S_BL_DIV: state_r <= S_BL_WAIT;
        S_BL_WAIT: begin
          if (div_done) begin
            res_r[ch_r] <= div_quo[7:0];
            if (ch_r == 2'd2) begin
              out_red_r   <= res_r[0];
              out_green_r <= res_r[1];
              out_blue_r  <= div_quo[7:0];
              out_alpha_r <= 8'hFF;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_BL_DIV;
            end
          end
        end
        S_VG_SQ1: begin
          sq_r    <= VW2'(ax * ax);
          state_r <= S_VG_SQ2;
        end
        S_VG_SQ2: begin
          sq_r    <= VW2'((sq_r + VW2'(ay * ay)) << 6);
          rem_r   <= '0;
          root_r  <= '0;
          it_r    <= '0;
          state_r <= S_VG_SQRT;
        end
        S_VG_SQRT: begin
          rem_r  <= sq_ge ? rem_sh - trial : rem_sh;
          root_r <= {root_r[RTW-2:0], sq_ge};
          sq_r   <= {sq_r[VW2-3:0], 2'b00};
          it_r   <= it_r + 1'b1;
          if (it_r == RIW'(RTW - 1)) state_r <= S_VG_DIV;
        end
        S_VG_DIV: begin
          if (vg_hit) begin
            state_r <= S_VG_WAIT;
          end else begin
            out_red_r   <= pix_r[7:0];
            out_green_r <= pix_r[15:8];
            out_blue_r  <= pix_r[23:16];
            out_alpha_r <= pix_r[31:24];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_VG_WAIT: begin
          if (div_done) begin
            fall_r  <= (div_quo > NW'(256)) ? 9'd256 : div_quo[8:0];
            state_r <= S_VG_FAC;
          end
        end
        S_VG_FAC: begin
          factor_r <= (dark >= 12'd256) ? 9'd0 : 9'(12'd256 - dark);
          state_r  <= S_VG_APPLY;
        end
        S_VG_APPLY: begin
          out_red_r   <= (vr[16:8] > 9'd255) ? 8'hFF : vr[15:8];
          out_green_r <= (vg[16:8] > 9'd255) ? 8'hFF : vg[15:8];
          out_blue_r  <= (vb[16:8] > 9'd255) ? 8'hFF : vb[15:8];
          out_alpha_r <= pix_r[31:24];
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign empty     = !out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_alpha = out_alpha_r;
endmodule

// ----- rtl/image_effect_engine.sv -----
`timescale 1ns / 1ps
// image_effect_engine: commands enter a 4-deep queue; the back end works one at a time.
// Write: the pushed pixel goes from the queue into the frame memory. Read: passthrough,
// grayscale and invert come from the pixel read; vignette runs a square root and a divide;
// blur sums the (2r+1)^2 window, one frame read a cycle, then divides each channel.
// Reset: config registers to defaults, queue and output empty; frame contents undefined.
module image_effect_engine
  import iee_pkg::*;
#(
  parameter int FRAME_SIZE = FRAME_SIZE_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_command,
  input  logic [7:0]  in_pos_x,
  input  logic [7:0]  in_pos_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int CW = $clog2(FRAME_SIZE);
  localparam int QW = 1 + 2 * CW + 32;

  cfg_t cfg_r;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.effect_mode       <= RST_EFFECT_MODE;
      cfg_r.blur_radius       <= RST_BLUR_RADIUS;
      cfg_r.vignette_strength <= RST_VIG_STRENGTH;
      cfg_r.vignette_radius   <= RST_VIG_RADIUS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EFFECT_MODE:  cfg_r.effect_mode       <= cfg_data[2:0];
        CFG_BLUR_RADIUS:  cfg_r.blur_radius       <= cfg_data[4:0];
        CFG_VIG_STRENGTH: cfg_r.vignette_strength <= cfg_data[10:0];
        CFG_VIG_RADIUS:   cfg_r.vignette_radius   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: saturate coordinates to the frame and pack the command
  logic [10:0]   xe, ye;
  logic [CW-1:0] xc, yc;
  assign xe = {3'b000, in_pos_x};
  assign ye = {3'b000, in_pos_y};
  assign xc = (xe > 11'(FRAME_SIZE - 1)) ? CW'(FRAME_SIZE - 1) : CW'(xe);
  assign yc = (ye > 11'(FRAME_SIZE - 1)) ? CW'(FRAME_SIZE - 1) : CW'(ye);

  logic [QW-1:0] q_in, q_out;
  logic          q_empty, q_pop;
  assign q_in = {in_command, xc, yc, in_alpha, in_blue, in_green, in_red};

  iee_cmd_fifo #(.W(QW), .DEPTH(CMD_FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(push), .wr_data(q_in), .rd_en(q_pop),
    .rd_data(q_out), .full(full), .empty(q_empty)
  );

  iee_back #(.FRAME_SIZE(FRAME_SIZE), .MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .cmd_valid(!q_empty),
    .cmd_read(q_out[QW-1]),
    .cmd_x(q_out[QW-2 -: CW]),
    .cmd_y(q_out[QW-2-CW -: CW]),
    .cmd_pixel(q_out[31:0]),
    .cmd_pop(q_pop),
    .pop(pop), .empty(empty),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha)
  );
endmodule

// ----- tb/sv/image_effect_engine_tb.sv -----
`timescale 1ns / 1ps
// image_effect_engine_tb: self-checking testbench of the image effect engine.
// Depends on rtl/iee_pkg.sv and rtl/image_effect_engine.sv; predicts every read in-line.
module image_effect_engine_tb;
  import iee_pkg::*;

  localparam int FRAME = 256;
  localparam int RADIUS_CAP = 30;
  localparam int SETTLE_CYCLES = 60;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_command = 1'b0;
  logic [7:0]  in_pos_x = '0;
  logic [7:0]  in_pos_y = '0;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic [7:0]  in_alpha = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor state: frame copy, written map, live register values
  logic [31:0] frame_mem [0:FRAME*FRAME-1];
  bit          pix_written [0:FRAME*FRAME-1];
  int          written_list[$];
  cfg_t        regs;
  pixel_t      pending_pixels[$];
  int          fail_count = 0;
  int          rx_hold = 0;
  bit          no_idle = 1'b0;

  image_effect_engine u_top (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic int sat_coord(int v);
    if (v < 0) return 0;
    if (v > FRAME - 1) return FRAME - 1;
    return v;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res = 0;
    longint b = longint'(1) << 40;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic pixel_t effect_of(int x, int y);
    pixel_t p;
    logic [31:0] w;
    longint sr, sg, sb, cnt, hx, hy, rad_q4, fall, dark, fac, g;
    int r;
    w = frame_mem[y*FRAME + x];
    p = '{w[7:0], w[15:8], w[23:16], w[31:24]};
    case (regs.effect_mode)
      MODE_BLUR: begin
        r = regs.blur_radius;
        if (r < 1) r = 1;
        if (r > RADIUS_CAP) r = RADIUS_CAP;
        sr = 0; sg = 0; sb = 0;
        for (int ky = -r; ky <= r; ky++)
          for (int kx = -r; kx <= r; kx++) begin
            w = frame_mem[sat_coord(y+ky)*FRAME + sat_coord(x+kx)];
            sr += w[7:0]; sg += w[15:8]; sb += w[23:16];
          end
        cnt = (2*r+1)*(2*r+1);
        p.red = 8'(sr / cnt); p.green = 8'(sg / cnt); p.blue = 8'(sb / cnt);
        p.alpha = 8'hFF;
      end
      MODE_VIGNETTE: begin
        hx = 2*x - FRAME; hy = 2*y - FRAME;
        rad_q4 = int_sqrt((hx*hx + hy*hy) * 64);
        if (rad_q4 > regs.vignette_radius) begin
          fall = ((rad_q4 - regs.vignette_radius) * 32) / FRAME;
          if (fall > 256) fall = 256;
          dark = (fall * regs.vignette_strength) >> 8;
          fac = (dark >= 256) ? 0 : 256 - dark;
          sr = (p.red * fac) >> 8; sg = (p.green * fac) >> 8; sb = (p.blue * fac) >> 8;
          p.red = (sr > 255) ? 8'hFF : 8'(sr);
          p.green = (sg > 255) ? 8'hFF : 8'(sg);
          p.blue = (sb > 255) ? 8'hFF : 8'(sb);
        end
      end
      MODE_GRAY: begin
        g = (longint'(GRAY_WR)*p.red + longint'(GRAY_WG)*p.green
             + longint'(GRAY_WB)*p.blue) >> 16;
        p.red = 8'(g); p.green = 8'(g); p.blue = 8'(g);
      end
      MODE_INVERT: begin
        p.red = ~p.red; p.green = ~p.green; p.blue = ~p.blue;
      end
      default: ;
    endcase
    return p;
  endfunction

  // ---------------- stimulus drivers ----------------
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one input transaction; prediction happens at the accepting edge
  task automatic send_item(logic cmd, logic [7:0] x, logic [7:0] y, logic [31:0] rgba);
    int gap;
    int idx;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_command <= cmd;
    in_pos_x <= x;
    in_pos_y <= y;
    {in_alpha, in_blue, in_green, in_red} <= rgba;
    do @(posedge clk); while (full);
    idx = int'(y)*FRAME + int'(x);
    if (cmd == CMD_WRITE) begin
      frame_mem[idx] = rgba;
      if (!pix_written[idx]) written_list.push_back(idx);
      pix_written[idx] = 1'b1;
    end else begin
      pending_pixels.push_back(effect_of(x, y));
    end
  endtask

  task automatic write_px(int x, int y, logic [31:0] rgba);
    send_item(CMD_WRITE, 8'(x), 8'(y), rgba);
  endtask

  task automatic read_px(int x, int y);
    send_item(CMD_READ, 8'(x), 8'(y), $urandom);
  endtask

  task automatic read_any_written();
    int idx;
    idx = written_list[$urandom_range(0, written_list.size()-1)];
    read_px(idx % FRAME, idx / FRAME);
  endtask

  // sender pauses until every expected pixel has come back, then lets writes land
  task automatic drain();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_EFFECT_MODE: regs.effect_mode = data[2:0];
      CFG_BLUR_RADIUS: regs.blur_radius = data[4:0];
      CFG_VIG_STRENGTH: regs.vignette_strength = data[10:0];
      default: regs.vignette_radius = data;
    endcase
  endtask

  task automatic set_config(logic [2:0] mode, logic [4:0] rad, logic [10:0] str,
                            logic [15:0] vrad);
    drain();
    write_reg(CFG_EFFECT_MODE, 16'(mode));
    write_reg(CFG_BLUR_RADIUS, 16'(rad));
    write_reg(CFG_VIG_STRENGTH, 16'(str));
    write_reg(CFG_VIG_RADIUS, vrad);
    cfg_valid <= 1'b0;
  endtask

  // ---------------- result checking ----------------
  task automatic check_result();
    pixel_t exp_px;
    if (pending_pixels.size() == 0) begin
      $error("unexpected result red=%0d green=%0d blue=%0d alpha=%0d",
             out_red, out_green, out_blue, out_alpha);
      fail_count++;
      return;
    end
    exp_px = pending_pixels.pop_front();
    if (out_red !== exp_px.red) begin
      $error("out_red expected %0d actual %0d", exp_px.red, out_red);
      fail_count++;
    end
    if (out_green !== exp_px.green) begin
      $error("out_green expected %0d actual %0d", exp_px.green, out_green);
      fail_count++;
    end
    if (out_blue !== exp_px.blue) begin
      $error("out_blue expected %0d actual %0d", exp_px.blue, out_blue);
      fail_count++;
    end
    if (out_alpha !== exp_px.alpha) begin
      $error("out_alpha expected %0d actual %0d", exp_px.alpha, out_alpha);
      fail_count++;
    end
  endtask

  // receiver: random pops, occasional long stalls, counted hold-offs
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) check_result();
      if (rx_hold > 0) rx_hold--;
      else if (!no_idle && $urandom_range(0, 59) == 0) rx_hold = $urandom_range(10, 40);
      pop <= (rx_hold == 0) && (no_idle || $urandom_range(0, 3) != 0);
    end
  end

  // ---------------- tests ----------------
  // corner and centre pixels with extreme values under the reset configuration
  task automatic test_reset_passthrough();
    write_px(0, 0, 32'h00000000);
    write_px(255, 255, 32'hFFFFFFFF);
    write_px(0, 255, 32'hFF00FF00);
    write_px(255, 0, 32'h00FF00FF);
    write_px(128, 128, 32'h80C0407F);
    read_px(0, 0);
    read_px(255, 255);
    read_px(0, 255);
    read_px(255, 0);
    read_px(128, 128);
  endtask

  // fill both blur corners so every window there is defined
  task automatic test_fill_blocks();
    no_idle = 1'b1;
    for (int y = 0; y < 8; y++)
      for (int x = 0; x < 8; x++) write_px(x, y, $urandom);
    for (int y = 252; y < 256; y++)
      for (int x = 252; x < 256; x++) write_px(x, y, $urandom);
    no_idle = 1'b0;
  endtask

  // every effect, out-of-range modes and radii, strength and radius extremes
  task automatic test_effects_directed();
    set_config(MODE_BLUR, 5'd0, RST_VIG_STRENGTH, RST_VIG_RADIUS);
    read_px(0, 0);
    read_px(255, 255);
    set_config(MODE_BLUR, 5'd7, RST_VIG_STRENGTH, RST_VIG_RADIUS);
    read_px(0, 0);
    set_config(MODE_BLUR, 5'd3, RST_VIG_STRENGTH, RST_VIG_RADIUS);
    read_px(255, 255);
    set_config(MODE_VIGNETTE, RST_BLUR_RADIUS, RST_VIG_STRENGTH, RST_VIG_RADIUS);
    read_px(0, 0);
    read_px(128, 128);
    set_config(MODE_VIGNETTE, RST_BLUR_RADIUS, 11'd256, 16'd0);
    read_px(255, 255);
    read_px(0, 255);
    set_config(MODE_VIGNETTE, RST_BLUR_RADIUS, 11'd2047, 16'd0);
    read_px(255, 0);
    set_config(MODE_VIGNETTE, RST_BLUR_RADIUS, 11'd0, 16'hFFFF);
    read_px(0, 0);
    set_config(MODE_GRAY, RST_BLUR_RADIUS, 11'd1024, RST_VIG_RADIUS);
    read_px(255, 255);
    read_px(128, 128);
    set_config(MODE_INVERT, RST_BLUR_RADIUS, 11'd1024, RST_VIG_RADIUS);
    read_px(0, 0);
    read_px(128, 128);
    set_config(MODE_SPARE_LO, RST_BLUR_RADIUS, 11'd1024, RST_VIG_RADIUS);
    read_px(255, 255);
    set_config(MODE_SPARE_HI, RST_BLUR_RADIUS, 11'd1024, RST_VIG_RADIUS);
    read_px(0, 255);
  endtask

  // random phases: one per mode code, random registers, mixed writes and reads
  task automatic test_random_phases();
    int r;
    int x;
    int y;
    logic [4:0] rad;
    logic [15:0] vrad;
    for (int ph = 0; ph < 8; ph++) begin
      rad = 5'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: vrad = 16'hFFFF;
        1: vrad = 16'd0;
        default: vrad = 16'($urandom_range(0, 3000));
      endcase
      set_config(3'(ph), rad, 11'($urandom_range(0, 2047)), vrad);
      r = (rad < 1) ? 1 : ((rad > RADIUS_CAP) ? RADIUS_CAP : rad);
      for (int n = 0; n < 6; n++) begin
        if ($urandom_range(0, 9) < 4) begin
          if ($urandom_range(0, 2) == 0) write_px($urandom_range(0, 31), $urandom_range(0, 31),
                                                  $urandom);
          else write_px($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
        end else if (3'(ph) == MODE_BLUR) begin
          if (r <= 3 && $urandom_range(0, 1)) begin
            x = $urandom_range(252 + r, 255);
            y = $urandom_range(252 + r, 255);
          end else begin
            x = $urandom_range(0, 7 - r);
            y = $urandom_range(0, 7 - r);
          end
          read_px(x, y);
        end else begin
          read_any_written();
        end
      end
    end
  endtask

  // receiver holds off long enough for the queue to fill and stall the input
  task automatic test_backpressure();
    set_config(MODE_INVERT, RST_BLUR_RADIUS, RST_VIG_STRENGTH, RST_VIG_RADIUS);
    rx_hold = 400;
    no_idle = 1'b1;
    for (int n = 0; n < 16; n++) read_any_written();
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    regs = '{RST_EFFECT_MODE, RST_BLUR_RADIUS, RST_VIG_STRENGTH, RST_VIG_RADIUS};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_passthrough();
    test_fill_blocks();
    test_effects_directed();
    test_backpressure();
    test_random_phases();
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
